[rtl/sem_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pkg
// Shared widths, register indexes and types of the Sobel edge magnitude stream.
// ----------------------------------------------------------------------------
package sem_pkg;

  // Pixel and position widths
  localparam int PIX_W     = 8;
  localparam int COL_W     = 10;
  localparam int ROW_W     = 11;
  localparam int CFG_W     = 11;
  localparam int MAG_W     = 8;
  localparam int CFG_IDX_W = 2;

  // Line store geometry
  localparam int MAX_WIDTH = 1024;
  localparam int ROW_LIMIT = 1024;
  localparam int MAG_LIMIT = 255;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

  // Per-item tag carried alongside the window
  typedef struct packed {
    logic             has_res;  // item produces a result
    logic             border;   // result pixel is on the frame border
    logic             last;     // result pixel is the frame's final one
    logic [COL_W-1:0] qr;       // result row
    logic [COL_W-1:0] qc;       // result column
  } tag_t;

  // 3x3 window, indexed [row][col], col 2 is the newest
  typedef logic [2:0][2:0][PIX_W-1:0] win_t;

endpackage
`default_nettype wire

[rtl/sem_ram.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module sem_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read, returns old data on a same-address write
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule
`default_nettype wire

[rtl/sem_pos.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_pos
// Frame geometry registers and raster position counter; tags each request
// with the position of the result it yields.
// ----------------------------------------------------------------------------
module sem_pos (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration writes
  input  wire logic                           cfg_valid_i,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sem_pkg::CFG_W-1:0]      cfg_data_i,
  // current request
  input  wire logic                           accept_i,
  input  wire logic                           kind_i,
  input  wire logic [sem_pkg::PIX_W-1:0]      pixel_i,
  output logic      [sem_pkg::COL_W-1:0]      addr_o,
  output logic      [sem_pkg::PIX_W-1:0]      pix_o,
  output sem_pkg::tag_t                       tag_o
);

  logic [sem_pkg::CFG_W-1:0] width_q, height_q;
  logic [sem_pkg::CFG_W-1:0] cfg_clamp;
  logic [sem_pkg::ROW_W-1:0] row_q, row_d;
  logic [sem_pkg::COL_W-1:0] col_q, col_d;
  logic [sem_pkg::ROW_W-1:0] qr_full;
  logic [sem_pkg::CFG_W-1:0] qc_full;
  logic [sem_pkg::CFG_W-1:0] width_m1, height_m1;
  logic [sem_pkg::CFG_W-1:0] col_inc;
  logic                      cfg_hit;

  // Saturate the written value to 1..1024
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_clamp = sem_pkg::CFG_W'(1);
    end else if (cfg_data_i > sem_pkg::CFG_W'(sem_pkg::MAX_WIDTH)) begin
      cfg_clamp = sem_pkg::CFG_W'(sem_pkg::MAX_WIDTH);
    end else begin
      cfg_clamp = cfg_data_i;
    end
  end

  assign cfg_hit = cfg_valid_i && ((cfg_index_i == sem_pkg::REG_FRAME_WIDTH) ||
                                   (cfg_index_i == sem_pkg::REG_FRAME_HEIGHT));

  // Geometry registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= sem_pkg::CFG_W'(sem_pkg::MAX_WIDTH);
      height_q <= sem_pkg::CFG_W'(sem_pkg::ROW_LIMIT);
    end else if (cfg_valid_i) begin
      if (cfg_index_i == sem_pkg::REG_FRAME_WIDTH) begin
        width_q <= cfg_clamp;
      end
      if (cfg_index_i == sem_pkg::REG_FRAME_HEIGHT) begin
        height_q <= cfg_clamp;
      end
    end
  end

  assign width_m1  = width_q - 1'b1;
  assign height_m1 = height_q - 1'b1;

  // Pixel value: flush items and drain rows feed zero
  assign pix_o  = (!kind_i && (row_q < height_q)) ? pixel_i : '0;
  assign addr_o = col_q;

  // Position of the pixel one row and one column behind
  always_comb begin
    if (col_q != '0) begin
      qr_full = row_q - 1'b1;
      qc_full = {1'b0, col_q} - 1'b1;
    end else begin
      qr_full = row_q - 2'd2;
      qc_full = width_m1;
    end
  end

  always_comb begin
    tag_o.has_res = (row_q >= sem_pkg::ROW_W'(2)) ||
                    ((row_q == sem_pkg::ROW_W'(1)) && (col_q != '0));
    tag_o.border  = (qr_full == '0) || (qr_full >= height_m1) ||
                    (qc_full == '0) || (qc_full >= width_m1);
    tag_o.last    = (qr_full == height_m1) && (qc_full == width_m1);
    tag_o.qr      = qr_full[sem_pkg::COL_W-1:0];
    tag_o.qc      = qc_full[sem_pkg::COL_W-1:0];
  end

  // Raster advance, restart after the last drain item
  assign col_inc = {1'b0, col_q} + 1'b1;
  always_comb begin
    if (row_q >= (height_q + 1'b1)) begin
      row_d = '0;
      col_d = '0;
    end else if (col_inc >= width_q) begin
      row_d = row_q + 1'b1;
      col_d = '0;
    end else begin
      row_d = row_q;
      col_d = col_inc[sem_pkg::COL_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
      col_q <= '0;
    end else if (cfg_hit) begin
      row_q <= '0;
      col_q <= '0;
    end else if (accept_i) begin
      row_q <= row_d;
      col_q <= col_d;
    end
  end

endmodule
`default_nettype wire

[rtl/sem_window.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_window
// Input register, paired line store with write-back bypass, and the 3x3
// window shift register.
// ----------------------------------------------------------------------------
module sem_window (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  // request side
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire logic [sem_pkg::COL_W-1:0]  addr_i,
  input  wire logic [sem_pkg::PIX_W-1:0]  pix_i,
  input  wire sem_pkg::tag_t              tag_i,
  // window side
  output logic                            valid_o,
  input  wire logic                       ready_i,
  output sem_pkg::win_t                   win_o,
  output sem_pkg::tag_t                   tag_o
);

  localparam int PAIR_W = 2 * sem_pkg::PIX_W;

  logic                       s1_v_q;
  logic [sem_pkg::COL_W-1:0]  s1_addr_q;
  logic [sem_pkg::PIX_W-1:0]  s1_pix_q;
  sem_pkg::tag_t              s1_tag_q;
  logic                       s2_v_q;
  sem_pkg::tag_t              s2_tag_q;
  sem_pkg::win_t              win_q;
  logic                       byp_v_q;
  logic [sem_pkg::COL_W-1:0]  byp_addr_q;
  logic [PAIR_W-1:0]          byp_data_q;
  logic [PAIR_W-1:0]          rd_pair, pair, wr_pair;
  logic                       load, s1_move, s2_ready;

  // Stage readiness; an item without a result leaves stage 2 freely
  assign s2_ready = !s2_v_q || !s2_tag_q.has_res || ready_i;
  assign s1_move  = s1_v_q && s2_ready;
  assign ready_o  = !s1_v_q || s2_ready;
  assign load     = valid_i && ready_o;

  // Line store: {upper, middle} per column
  sem_ram #(
    .WIDTH (PAIR_W),
    .DEPTH (sem_pkg::MAX_WIDTH)
  ) u_line (
    .clk_i   (clk_i),
    .we_i    (s1_move),
    .waddr_i (s1_addr_q),
    .wdata_i (wr_pair),
    .re_i    (load),
    .raddr_i (addr_i),
    .rdata_o (rd_pair)
  );

  // Forward the latest write when it hit the same column
  assign pair    = (byp_v_q && (byp_addr_q == s1_addr_q)) ? byp_data_q : rd_pair;
  assign wr_pair = {pair[sem_pkg::PIX_W-1:0], s1_pix_q};

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      byp_v_q <= 1'b0;
    end else begin
      s1_v_q <= load || (s1_v_q && !s1_move);
      s2_v_q <= s1_move || (s2_v_q && !s2_ready);
      if (s1_move) begin
        byp_v_q <= 1'b1;
      end
    end
  end

  // Payload
  always_ff @(posedge clk_i) begin
    if (load) begin
      s1_addr_q <= addr_i;
      s1_pix_q  <= pix_i;
      s1_tag_q  <= tag_i;
    end
    if (s1_move) begin
      byp_addr_q <= s1_addr_q;
      byp_data_q <= wr_pair;
      s2_tag_q   <= s1_tag_q;
      for (int i = 0; i < 3; i++) begin
        win_q[i][0] <= win_q[i][1];
        win_q[i][1] <= win_q[i][2];
      end
      win_q[0][2] <= pair[PAIR_W-1:sem_pkg::PIX_W];
      win_q[1][2] <= pair[sem_pkg::PIX_W-1:0];
      win_q[2][2] <= s1_pix_q;
    end
  end

  assign valid_o = s2_v_q && s2_tag_q.has_res;
  assign win_o   = win_q;
  assign tag_o   = s2_tag_q;

endmodule
`default_nettype wire

[rtl/sem_grad.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sem_grad
// Sobel gradient, L1 magnitude with clamp, and the result register.
// ----------------------------------------------------------------------------
module sem_grad (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       valid_i,
  output logic                            ready_o,
  input  wire sem_pkg::win_t              win_i,
  input  wire sem_pkg::tag_t              tag_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic      [sem_pkg::MAG_W-1:0]  out_magnitude_o,
  output logic      [sem_pkg::COL_W-1:0]  out_row_o,
  output logic      [sem_pkg::COL_W-1:0]  out_col_o,
  output logic                            out_frame_last_o
);

  localparam int SUM_W = sem_pkg::PIX_W + 2;

  logic [SUM_W-1:0]           left, right, top, bottom;
  logic signed [SUM_W:0]      gx, gy;
  logic [SUM_W-1:0]           ax, ay;
  logic [SUM_W:0]             sum;
  logic [sem_pkg::MAG_W-1:0]  mag;
  logic                       load;

  // Weighted column and row sums
  always_comb begin
    left   = SUM_W'(win_i[0][0]) + {1'b0, win_i[1][0], 1'b0} + SUM_W'(win_i[2][0]);
    right  = SUM_W'(win_i[0][2]) + {1'b0, win_i[1][2], 1'b0} + SUM_W'(win_i[2][2]);
    top    = SUM_W'(win_i[0][0]) + {1'b0, win_i[0][1], 1'b0} + SUM_W'(win_i[0][2]);
    bottom = SUM_W'(win_i[2][0]) + {1'b0, win_i[2][1], 1'b0} + SUM_W'(win_i[2][2]);
  end

  // Gradients and absolute sum
  assign gx  = $signed({1'b0, right}) - $signed({1'b0, left});
  assign gy  = $signed({1'b0, top}) - $signed({1'b0, bottom});
  assign ax  = gx[SUM_W] ? SUM_W'(-gx) : SUM_W'(gx);
  assign ay  = gy[SUM_W] ? SUM_W'(-gy) : SUM_W'(gy);
  assign sum = {1'b0, ax} + {1'b0, ay};

  // Clamp; border pixels answer zero
  always_comb begin
    if (tag_i.border) begin
      mag = '0;
    end else if (sum > (SUM_W + 1)'(sem_pkg::MAG_LIMIT)) begin
      mag = sem_pkg::MAG_W'(sem_pkg::MAG_LIMIT);
    end else begin
      mag = sum[sem_pkg::MAG_W-1:0];
    end
  end

  assign ready_o = !out_valid_o || !out_stall_i;
  assign load    = valid_i && ready_o;

  // Result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ready_o) begin
      out_valid_o <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_magnitude_o  <= mag;
      out_row_o        <= tag_i.qr;
      out_col_o        <= tag_i.qc;
      out_frame_last_o <= tag_i.last;
    end
  end

endmodule
`default_nettype wire

[rtl/sobel_edge_magnitude_stream.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sobel_edge_magnitude_stream
// Streaming 3x3 Sobel edge detector with clamped |Gx|+|Gy| magnitude.
// ----------------------------------------------------------------------------
// Takes one grey pixel per clock in raster order and returns one result per
// clock at full rate when the output is not stalled; each result passes
// the input, window and result registers after its window is complete.
// The rate is set by the line store, a 1024 x 16 dual-port RAM read and
// written once per request, with a one-entry bypass covering a write-back to
// the column just read. Each result is for the pixel one row and one column
// behind the newest request; the first width+1 requests of a frame give none
// and width+1 flush requests after the frame drain the rest. Border pixels
// give zero. The line store is not cleared at reset: its contents only feed
// border results until the first rows of a frame have been written. The
// configuration port is always ready; a write to either geometry register
// restarts the frame and must only be issued while the block is idle.
// ----------------------------------------------------------------------------
module sobel_edge_magnitude_stream (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  // configuration
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [sem_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [sem_pkg::CFG_W-1:0]      cfg_data_i,
  // pixel input
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic                           in_kind_i,
  input  wire logic [sem_pkg::PIX_W-1:0]      in_pixel_i,
  // results
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [sem_pkg::MAG_W-1:0]      out_magnitude_o,
  output logic      [sem_pkg::COL_W-1:0]      out_row_o,
  output logic      [sem_pkg::COL_W-1:0]      out_col_o,
  output logic                                out_frame_last_o
);

  logic                       in_ready, in_accept;
  logic [sem_pkg::COL_W-1:0]  pos_addr;
  logic [sem_pkg::PIX_W-1:0]  pos_pix;
  sem_pkg::tag_t              pos_tag;
  logic                       win_valid, grad_ready;
  sem_pkg::win_t              win;
  sem_pkg::tag_t              win_tag;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = !in_ready;
  assign in_accept   = in_valid_i && in_ready;

  // Geometry and raster position
  sem_pos u_pos (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .accept_i    (in_accept),
    .kind_i      (in_kind_i),
    .pixel_i     (in_pixel_i),
    .addr_o      (pos_addr),
    .pix_o       (pos_pix),
    .tag_o       (pos_tag)
  );

  // Line store and window
  sem_window u_window (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .ready_o (in_ready),
    .addr_i  (pos_addr),
    .pix_i   (pos_pix),
    .tag_i   (pos_tag),
    .valid_o (win_valid),
    .ready_i (grad_ready),
    .win_o   (win),
    .tag_o   (win_tag)
  );

  // Magnitude and result register
  sem_grad u_grad (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .valid_i          (win_valid),
    .ready_o          (grad_ready),
    .win_i            (win),
    .tag_i            (win_tag),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .out_magnitude_o  (out_magnitude_o),
    .out_row_o        (out_row_o),
    .out_col_o        (out_col_o),
    .out_frame_last_o (out_frame_last_o)
  );

`ifndef SYNTHESIS
  // Input only backs up behind a result that is held at the output
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without a held result");

  // Top row and left column are border pixels and answer zero
  a_border_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && ((out_row_o == '0) || (out_col_o == '0))) |->
      (out_magnitude_o == '0))
    else $error("nonzero magnitude on a border pixel");

  // A stalled result stays valid until the stall is released
  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> out_valid_o)
    else $error("stalled result dropped");
`endif

endmodule
`default_nettype wire
